FILE: rtl/hrhp_pkg.sv
// Package for the HTTP request header parser: phase encodings, state record,
// result codes and the keyword character tables.
// Depends on nothing; used by rtl/http_request_header_parser.sv.
package hrhp_pkg;

  // Request-level phase, one-hot.
  typedef enum logic [2:0] {
    PH_REQ  = 3'b001,
    PH_HDR  = 3'b010,
    PH_DONE = 3'b100
  } main_phase_e;

  // Token phases on the request line.
  localparam logic [2:0] TP_METHOD  = 3'd0;
  localparam logic [2:0] TP_SEP1    = 3'd1;
  localparam logic [2:0] TP_URL     = 3'd2;
  localparam logic [2:0] TP_SEP2    = 3'd3;
  localparam logic [2:0] TP_VERSION = 3'd4;
  // Token phases on a header line.
  localparam logic [2:0] TP_HOST_KW  = 3'd0;
  localparam logic [2:0] TP_HOST_SEP = 3'd1;
  localparam logic [2:0] TP_HOST_VAL = 3'd2;
  localparam logic [2:0] TP_OTHER    = 3'd3;

  // URL parsing modes.
  localparam logic [1:0] PM_UNDECIDED = 2'd0;
  localparam logic [1:0] PM_PATH      = 2'd1;
  localparam logic [1:0] PM_SCHEME    = 2'd2;
  localparam logic [1:0] PM_HOST      = 2'd3;

  // Result codes.
  localparam logic [1:0] ST_NEED_MORE = 2'd0;
  localparam logic [1:0] ST_COMPLETE  = 2'd1;
  localparam logic [1:0] ST_BAD       = 2'd2;
  localparam logic [1:0] ST_TOO_LONG  = 2'd3;

  localparam logic [1:0] ROLE_OTHER = 2'd0;
  localparam logic [1:0] ROLE_PATH  = 2'd1;
  localparam logic [1:0] ROLE_HOST  = 2'd2;

  localparam logic [15:0] MAX_LENGTH_RESET = 16'd4096;

  localparam logic [3:0] GET_LEN     = 4'd3;
  localparam logic [3:0] VERSION_LEN = 4'd8;
  localparam logic [3:0] SCHEME_LEN  = 4'd7;
  localparam logic [3:0] HOST_LEN    = 4'd5;

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_SP    = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_H     = 8'h68;

  typedef struct packed {
    main_phase_e main_phase;
    logic [2:0]  token_phase;
    logic [3:0]  match_count;
    logic [1:0]  path_mode;
    logic        cr_pending;
    logic        line_error;
    logic        line_has_bytes;
    logic [15:0] bytes_seen;
    logic [1:0]  final_status;
  } parse_state_t;

  localparam parse_state_t STATE_CLEAR = '{
    main_phase: PH_REQ, token_phase: 3'd0, match_count: 4'd0, path_mode: 2'd0,
    cr_pending: 1'b0, line_error: 1'b0, line_has_bytes: 1'b0,
    bytes_seen: 16'd0, final_status: ST_NEED_MORE
  };

  function automatic logic [7:0] to_lower(input logic [7:0] b);
    to_lower = (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b;
  endfunction

  function automatic logic is_sep(input logic [7:0] b);
    is_sep = (b == CHAR_SP) || (b == CHAR_TAB);
  endfunction

  function automatic logic [7:0] kw_get(input logic [3:0] idx);
    case (idx)
      4'd0:    kw_get = "g";
      4'd1:    kw_get = "e";
      4'd2:    kw_get = "t";
      default: kw_get = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] kw_version(input logic [3:0] idx);
    case (idx)
      4'd0:    kw_version = "h";
      4'd1:    kw_version = "t";
      4'd2:    kw_version = "t";
      4'd3:    kw_version = "p";
      4'd4:    kw_version = "/";
      4'd5:    kw_version = "1";
      4'd6:    kw_version = ".";
      4'd7:    kw_version = "1";
      default: kw_version = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] kw_scheme(input logic [3:0] idx);
    case (idx)
      4'd0:    kw_scheme = "h";
      4'd1:    kw_scheme = "t";
      4'd2:    kw_scheme = "t";
      4'd3:    kw_scheme = "p";
      4'd4:    kw_scheme = ":";
      4'd5:    kw_scheme = "/";
      4'd6:    kw_scheme = "/";
      default: kw_scheme = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] kw_host(input logic [3:0] idx);
    case (idx)
      4'd0:    kw_host = "h";
      4'd1:    kw_host = "o";
      4'd2:    kw_host = "s";
      4'd3:    kw_host = "t";
      4'd4:    kw_host = ":";
      default: kw_host = 8'h00;
    endcase
  endfunction

endpackage

FILE: rtl/http_request_header_parser.sv
// HTTP request line and header parser: one status word per request byte.
// Depends on rtl/hrhp_pkg.sv.
//
// Channel   Dir  Handshake                    Contents
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata: data_byte; tuser: restart
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: status, byte_role
// cfg       in   cfg_valid_i/cfg_ready_o      cfg_data_i: max_length
//
// One byte is taken per cycle when the output is not stalled; its result appears
// in the output register on the next cycle. The parser state updates in the same
// cycle the byte is taken, so the per-byte decode between the input and the output
// register sets the rate. The input is ready whenever the output register is empty
// or being emptied. Reset clears the parser state and sets max_length to 4096.
module http_request_header_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [0:0]  s_axis_tuser,   // [0] restart
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [1:0] status, [3:2] byte_role, [7:4] zero
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  hrhp_pkg::parse_state_t state_q, state_d, cur;
  logic [15:0] max_length_q;
  logic        out_valid_q;
  logic [1:0]  status_q, role_q;
  logic [1:0]  status_d, role_d;
  logic        accept;
  logic [7:0]  b, lb;
  logic        sep;
  logic [1:0]  url_pm;
  logic [3:0]  url_mc, ver_mc;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, role_q, status_q};

  assign b   = s_axis_tdata;
  assign lb  = hrhp_pkg::to_lower(s_axis_tdata);
  assign sep = hrhp_pkg::is_sep(s_axis_tdata);

  always_comb begin
    cur      = s_axis_tuser[0] ? hrhp_pkg::STATE_CLEAR : state_q;
    state_d  = cur;
    status_d = hrhp_pkg::ST_NEED_MORE;
    role_d   = hrhp_pkg::ROLE_OTHER;
    // Entering the URL from the separator phase starts with a fresh mode.
    url_pm = (cur.token_phase == hrhp_pkg::TP_SEP1) ? hrhp_pkg::PM_UNDECIDED : cur.path_mode;
    url_mc = (cur.token_phase == hrhp_pkg::TP_SEP1) ? 4'd0 : cur.match_count;
    ver_mc = (cur.token_phase == hrhp_pkg::TP_SEP2) ? 4'd0 : cur.match_count;

    if (cur.main_phase == hrhp_pkg::PH_DONE) begin
      status_d = cur.final_status;
    end else if (cur.bytes_seen >= max_length_q) begin
      status_d               = hrhp_pkg::ST_TOO_LONG;
      state_d.final_status   = hrhp_pkg::ST_TOO_LONG;
      state_d.main_phase     = hrhp_pkg::PH_DONE;
    end else begin
      state_d.bytes_seen = cur.bytes_seen + 16'd1;
      if (cur.cr_pending) begin
        if (b != hrhp_pkg::CHAR_LF) begin
          status_d = hrhp_pkg::ST_BAD;
        end else if (cur.main_phase == hrhp_pkg::PH_REQ) begin
          if (!cur.line_error && cur.token_phase == hrhp_pkg::TP_VERSION &&
              cur.match_count == hrhp_pkg::VERSION_LEN) begin
            state_d                = hrhp_pkg::STATE_CLEAR;
            state_d.main_phase     = hrhp_pkg::PH_HDR;
            state_d.bytes_seen     = cur.bytes_seen + 16'd1;
          end else begin
            status_d = hrhp_pkg::ST_BAD;
          end
        end else if (!cur.line_has_bytes) begin
          status_d = hrhp_pkg::ST_COMPLETE;
        end else begin
          state_d            = hrhp_pkg::STATE_CLEAR;
          state_d.main_phase = hrhp_pkg::PH_HDR;
          state_d.bytes_seen = cur.bytes_seen + 16'd1;
        end
      end else if (b == hrhp_pkg::CHAR_CR) begin
        state_d.cr_pending = 1'b1;
      end else if (b == hrhp_pkg::CHAR_LF) begin
        status_d = hrhp_pkg::ST_BAD;
      end else begin
        state_d.line_has_bytes = 1'b1;
        if (cur.main_phase == hrhp_pkg::PH_REQ) begin
          if (!cur.line_error) begin
            case (cur.token_phase)
              hrhp_pkg::TP_METHOD: begin
                if (sep) begin
                  if (cur.match_count == hrhp_pkg::GET_LEN) begin
                    state_d.token_phase = hrhp_pkg::TP_SEP1;
                  end else begin
                    state_d.line_error = 1'b1;
                  end
                end else if (cur.match_count < hrhp_pkg::GET_LEN &&
                             lb == hrhp_pkg::kw_get(cur.match_count)) begin
                  state_d.match_count = cur.match_count + 4'd1;
                end else begin
                  state_d.line_error = 1'b1;
                end
              end
              hrhp_pkg::TP_SEP1, hrhp_pkg::TP_URL: begin
                if (!(cur.token_phase == hrhp_pkg::TP_SEP1 && sep)) begin
                  state_d.token_phase = hrhp_pkg::TP_URL;
                  state_d.path_mode   = url_pm;
                  state_d.match_count = url_mc;
                  if (sep) begin
                    if (url_pm == hrhp_pkg::PM_PATH) begin
                      state_d.token_phase = hrhp_pkg::TP_SEP2;
                      state_d.match_count = 4'd0;
                    end else begin
                      state_d.line_error = 1'b1;
                    end
                  end else begin
                    case (url_pm)
                      hrhp_pkg::PM_UNDECIDED: begin
                        if (b == hrhp_pkg::CHAR_SLASH) begin
                          state_d.path_mode = hrhp_pkg::PM_PATH;
                          role_d            = hrhp_pkg::ROLE_PATH;
                        end else if (lb == hrhp_pkg::CHAR_H) begin
                          state_d.path_mode   = hrhp_pkg::PM_SCHEME;
                          state_d.match_count = 4'd1;
                        end else begin
                          state_d.line_error = 1'b1;
                        end
                      end
                      hrhp_pkg::PM_PATH: begin
                        role_d = hrhp_pkg::ROLE_PATH;
                      end
                      hrhp_pkg::PM_SCHEME: begin
                        if (url_mc < hrhp_pkg::SCHEME_LEN &&
                            lb == hrhp_pkg::kw_scheme(url_mc)) begin
                          state_d.match_count = url_mc + 4'd1;
                          if (url_mc + 4'd1 == hrhp_pkg::SCHEME_LEN) begin
                            state_d.path_mode = hrhp_pkg::PM_HOST;
                          end
                        end else begin
                          state_d.line_error = 1'b1;
                        end
                      end
                      default: begin
                        if (b == hrhp_pkg::CHAR_SLASH) begin
                          state_d.path_mode = hrhp_pkg::PM_PATH;
                          role_d            = hrhp_pkg::ROLE_PATH;
                        end
                      end
                    endcase
                  end
                end
              end
              hrhp_pkg::TP_SEP2, hrhp_pkg::TP_VERSION: begin
                if (!(cur.token_phase == hrhp_pkg::TP_SEP2 && sep)) begin
                  state_d.token_phase = hrhp_pkg::TP_VERSION;
                  state_d.match_count = ver_mc;
                  if (!sep && ver_mc < hrhp_pkg::VERSION_LEN &&
                      lb == hrhp_pkg::kw_version(ver_mc)) begin
                    state_d.match_count = ver_mc + 4'd1;
                  end else begin
                    state_d.line_error = 1'b1;
                  end
                end
              end
              default: begin
                state_d.line_error = 1'b1;
              end
            endcase
          end
        end else begin
          case (cur.token_phase)
            hrhp_pkg::TP_HOST_KW: begin
              if (cur.match_count < hrhp_pkg::HOST_LEN &&
                  lb == hrhp_pkg::kw_host(cur.match_count)) begin
                state_d.match_count = cur.match_count + 4'd1;
                if (cur.match_count + 4'd1 == hrhp_pkg::HOST_LEN) begin
                  state_d.token_phase = hrhp_pkg::TP_HOST_SEP;
                end
              end else begin
                state_d.token_phase = hrhp_pkg::TP_OTHER;
              end
            end
            hrhp_pkg::TP_HOST_SEP: begin
              if (!sep) begin
                state_d.token_phase = hrhp_pkg::TP_HOST_VAL;
                role_d              = hrhp_pkg::ROLE_HOST;
              end
            end
            hrhp_pkg::TP_HOST_VAL: begin
              role_d = hrhp_pkg::ROLE_HOST;
            end
            default: begin
              role_d = hrhp_pkg::ROLE_OTHER;
            end
          endcase
        end
      end
      if (status_d != hrhp_pkg::ST_NEED_MORE) begin
        state_d.final_status = status_d;
        state_d.main_phase   = hrhp_pkg::PH_DONE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= hrhp_pkg::STATE_CLEAR;
      max_length_q <= hrhp_pkg::MAX_LENGTH_RESET;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        max_length_q <= cfg_data_i;
      end
      if (accept) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      role_q   <= role_d;
    end
  end

  // Once a verdict is held, the byte count stays put until a restart.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.main_phase == hrhp_pkg::PH_DONE && !(accept && s_axis_tuser[0]))
      |=> $stable(state_q.bytes_seen))
    else $error("byte count moved after verdict");

  // A held verdict is never the need-more code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.main_phase == hrhp_pkg::PH_DONE |-> state_q.final_status != hrhp_pkg::ST_NEED_MORE)
    else $error("verdict phase without verdict");

  // A tagged byte never carries a verdict.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && role_q != hrhp_pkg::ROLE_OTHER) |-> status_q == hrhp_pkg::ST_NEED_MORE)
    else $error("byte role set on a verdict word");

  // A taken byte always yields a pending result word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("result word lost");

endmodule
